FILE: sv/robin_hood_hash_map_defines.svh
// Assertion macros shared by the checker of the Robin Hood hash map.
// Depends on nothing; the user must have clk_i and rst_ni in scope.
`ifndef ROBIN_HOOD_HASH_MAP_DEFINES_SVH
`define ROBIN_HOOD_HASH_MAP_DEFINES_SVH

// Property checked at every rising edge outside reset.
`define RHH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Property checked at every rising edge, reset included.
`define RHH_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: sv/rhh_pkg.sv
// Package of the Robin Hood hash map: sizes, codes, slot entry layout and
// the command and status structures between controller and datapath.
`default_nettype none

package rhh_pkg;

  localparam int SLOTS      = 256;
  localparam int IDX_W      = $clog2(SLOTS);
  localparam int CNT_W      = $clog2(SLOTS + 1);
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;
  localparam int DIST_W     = 7;
  localparam int FUNC_W     = 3;
  localparam int STATUS_W   = 3;
  localparam int SLOT_W     = 8;

  localparam logic [DIST_W-1:0] DIST_MAX   = DIST_W'(127);
  localparam logic [CNT_W-1:0]  LOAD_RESET = CNT_W'((SLOTS * 85) / 100);

  // Operation codes; codes five to seven are unused and behave as a miss.
  localparam logic [FUNC_W-1:0] FUNC_INSERT  = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_REPLACE = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_FIND    = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE  = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 3'd4;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 3'd0,
    ST_PRESENT  = 3'd1,
    ST_REPLACED = 3'd2,
    ST_FOUND    = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_REMOVED  = 3'd5,
    ST_FULL     = 3'd6,
    ST_CLEARED  = 3'd7
  } status_e;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_LOAD,
    ACT_MISS,
    ACT_CLEAR,
    ACT_READ_IDX,
    ACT_READ_NEXT,
    ACT_PLACE,
    ACT_HIT,
    ACT_SWAP,
    ACT_STEP,
    ACT_RM_HIT,
    ACT_SHIFT,
    ACT_RM_DONE,
    ACT_EMIT
  } act_e;

  typedef struct packed {
    logic [DIST_W-1:0]     pdist;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] val;
  } entry_t;

  typedef struct packed {
    logic              is_used;
    logic              nx_used;
    logic              key_hit;
    logic              d_gt;
    logic              dist_zero;
    logic              cnt_done;
    logic              full;
    logic [FUNC_W-1:0] func;
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: sv/rhh_if.sv
// Request and response channel interfaces of the Robin Hood hash map.
// Depends on rhh_pkg for the field widths.
`default_nettype none

interface rhh_req_if;
  logic                              valid;
  logic                              ready;
  logic [rhh_pkg::FUNC_W-1:0]        func;
  logic [rhh_pkg::KEY_BITS-1:0]      key;
  logic [rhh_pkg::VALUE_BITS-1:0]    value;
  logic [rhh_pkg::SLOT_W-1:0]        home_slot;

  modport source (output valid, func, key, value, home_slot, input ready);
  modport sink   (input valid, func, key, value, home_slot, output ready);
endinterface

interface rhh_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [rhh_pkg::STATUS_W-1:0]      status;
  logic [rhh_pkg::SLOT_W-1:0]        slot_index;
  logic [rhh_pkg::VALUE_BITS-1:0]    value_out;
  logic [rhh_pkg::CNT_W-1:0]         entry_count;

  modport source (output valid, status, slot_index, value_out, entry_count, input ready);
  modport sink   (input valid, status, slot_index, value_out, entry_count, output ready);
endinterface

`default_nettype wire

FILE: sv/rhh_dp.sv
// Datapath of the Robin Hood hash map: slot memory, used bits, probe
// registers, result and output registers. Depends on rhh_pkg.
`default_nettype none

module rhh_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rhh_pkg::CNT_W-1:0]      cfg_data_i,
  input  logic [rhh_pkg::FUNC_W-1:0]     req_func_i,
  input  logic [rhh_pkg::KEY_BITS-1:0]   req_key_i,
  input  logic [rhh_pkg::VALUE_BITS-1:0] req_value_i,
  input  logic [rhh_pkg::SLOT_W-1:0]     req_home_i,
  input  rhh_pkg::act_e                  act_i,
  output rhh_pkg::dp_stat_t              stat_o,
  output logic [rhh_pkg::STATUS_W-1:0]   out_status_o,
  output logic [rhh_pkg::SLOT_W-1:0]     out_slot_o,
  output logic [rhh_pkg::VALUE_BITS-1:0] out_value_o,
  output logic [rhh_pkg::CNT_W-1:0]      out_count_o
);
  import rhh_pkg::*;

  entry_t                mem_q [SLOTS];
  entry_t                rd_q;
  logic [SLOTS-1:0]      used_q;
  logic [CNT_W-1:0]      count_q;
  logic [CNT_W-1:0]      limit_q;
  logic [FUNC_W-1:0]     func_q;
  logic [KEY_BITS-1:0]   ck_q;
  logic [VALUE_BITS-1:0] cv_q;
  logic [VALUE_BITS-1:0] val_q;
  logic [IDX_W-1:0]      idx_q;
  logic [IDX_W-1:0]      last_q;
  logic [CNT_W-1:0]      d_q;
  logic [CNT_W-1:0]      n_q;
  logic                  placed_q;
  status_e               res_status_q;
  logic [IDX_W-1:0]      res_where_q;
  logic [VALUE_BITS-1:0] res_vout_q;
  logic [STATUS_W-1:0]   out_status_q;
  logic [SLOT_W-1:0]     out_slot_q;
  logic [VALUE_BITS-1:0] out_value_q;
  logic [CNT_W-1:0]      out_count_q;

  logic [IDX_W-1:0]      idx_nx;
  logic [IDX_W-1:0]      last_nx;
  logic [DIST_W-1:0]     d_sat;
  logic                  we;
  logic [IDX_W-1:0]      waddr;
  entry_t                wdata;
  logic                  re;
  logic [IDX_W-1:0]      raddr;
  logic                  is_ins;

  assign idx_nx  = (idx_q == IDX_W'(SLOTS - 1)) ? '0 : idx_q + 1'b1;
  assign last_nx = (last_q == IDX_W'(SLOTS - 1)) ? '0 : last_q + 1'b1;
  assign d_sat   = (d_q > CNT_W'(DIST_MAX)) ? DIST_MAX : d_q[DIST_W-1:0];
  assign is_ins  = (func_q == FUNC_INSERT) || (func_q == FUNC_REPLACE);

  always_comb begin
    stat_o.is_used   = used_q[idx_q];
    stat_o.nx_used   = used_q[last_nx];
    stat_o.key_hit   = (rd_q.key == ck_q);
    stat_o.d_gt      = (d_q > CNT_W'(rd_q.pdist));
    stat_o.dist_zero = (rd_q.pdist == '0);
    stat_o.cnt_done  = (n_q == CNT_W'(SLOTS));
    stat_o.full      = (count_q >= limit_q) || (count_q >= CNT_W'(SLOTS));
    stat_o.func      = func_q;
  end

  // Memory port selection.
  always_comb begin
    we    = 1'b0;
    waddr = idx_q;
    wdata = '{pdist: d_sat, key: ck_q, val: cv_q};
    re    = 1'b0;
    raddr = idx_q;
    unique case (act_i)
      ACT_READ_IDX: begin
        re = 1'b1;
      end
      ACT_READ_NEXT: begin
        re    = 1'b1;
        raddr = last_nx;
      end
      ACT_PLACE, ACT_SWAP: begin
        we = 1'b1;
      end
      ACT_HIT: begin
        we    = (func_q == FUNC_REPLACE);
        wdata = '{pdist: rd_q.pdist, key: rd_q.key, val: val_q};
      end
      ACT_SHIFT: begin
        we    = 1'b1;
        waddr = last_q;
        wdata = '{pdist: rd_q.pdist - 1'b1, key: rd_q.key, val: rd_q.val};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (re) begin
      rd_q <= mem_q[raddr];
    end
  end

  // Table occupancy and load limit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q  <= '0;
      count_q <= '0;
      limit_q <= LOAD_RESET;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_data_i;
      end
      unique case (act_i)
        ACT_CLEAR: begin
          used_q  <= '0;
          count_q <= '0;
        end
        ACT_PLACE: begin
          used_q[idx_q] <= 1'b1;
          count_q       <= count_q + 1'b1;
        end
        ACT_RM_DONE: begin
          used_q[last_q] <= 1'b0;
          if (count_q != '0) begin
            count_q <= count_q - 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Probe state and result registers.
  always_ff @(posedge clk_i) begin
    unique case (act_i)
      ACT_LOAD: begin
        func_q       <= req_func_i;
        ck_q         <= req_key_i;
        cv_q         <= req_value_i;
        val_q        <= req_value_i;
        idx_q        <= IDX_W'(req_home_i);
        d_q          <= '0;
        n_q          <= '0;
        placed_q     <= 1'b0;
        res_status_q <= ST_NOTFOUND;
        res_where_q  <= '0;
        res_vout_q   <= '0;
      end
      ACT_MISS: begin
        res_status_q <= is_ins ? ST_FULL : ST_NOTFOUND;
        res_where_q  <= '0;
      end
      ACT_CLEAR: begin
        res_status_q <= ST_CLEARED;
      end
      ACT_PLACE: begin
        if (!placed_q) begin
          res_where_q <= idx_q;
        end
        res_status_q <= ST_INSERTED;
        res_vout_q   <= val_q;
      end
      ACT_HIT: begin
        res_where_q <= idx_q;
        if (func_q == FUNC_REPLACE) begin
          res_status_q <= ST_REPLACED;
          res_vout_q   <= val_q;
        end else begin
          res_status_q <= (func_q == FUNC_FIND) ? ST_FOUND : ST_PRESENT;
          res_vout_q   <= rd_q.val;
        end
      end
      ACT_SWAP: begin
        if (!placed_q) begin
          res_where_q <= idx_q;
        end
        placed_q <= 1'b1;
        d_q      <= CNT_W'(rd_q.pdist) + 1'b1;
        ck_q     <= rd_q.key;
        cv_q     <= rd_q.val;
        idx_q    <= idx_nx;
        n_q      <= n_q + 1'b1;
      end
      ACT_STEP: begin
        d_q   <= d_q + 1'b1;
        idx_q <= idx_nx;
        n_q   <= n_q + 1'b1;
      end
      ACT_RM_HIT: begin
        res_status_q <= ST_REMOVED;
        res_where_q  <= idx_q;
        res_vout_q   <= rd_q.val;
        last_q       <= idx_q;
        n_q          <= '0;
      end
      ACT_SHIFT: begin
        last_q <= last_nx;
        n_q    <= n_q + 1'b1;
      end
      ACT_EMIT: begin
        out_status_q <= res_status_q;
        out_slot_q   <= SLOT_W'(res_where_q);
        out_value_q  <= res_vout_q;
        out_count_q  <= count_q;
      end
      default: begin
      end
    endcase
  end

  assign out_status_o = out_status_q;
  assign out_slot_o   = out_slot_q;
  assign out_value_o  = out_value_q;
  assign out_count_o  = out_count_q;

endmodule

`default_nettype wire

FILE: sv/rhh_ctrl.sv
// Controller of the Robin Hood hash map: one-hot state machine that walks
// the probe sequence and drives the datapath commands. Depends on rhh_pkg.
`default_nettype none

module rhh_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  output logic              rsp_valid_o,
  input  logic              rsp_ready_i,
  input  rhh_pkg::dp_stat_t stat_i,
  output rhh_pkg::act_e     act_o
);
  import rhh_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_START = 7'b0000010,
    S_READ  = 7'b0000100,
    S_EVAL  = 7'b0001000,
    S_SREAD = 7'b0010000,
    S_SEVAL = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   is_ins;

  assign is_ins = (stat_i.func == FUNC_INSERT) || (stat_i.func == FUNC_REPLACE);

  always_comb begin
    state_d     = state_q;
    act_o       = ACT_NONE;
    out_valid_d = out_valid_q;
    if (out_valid_q && rsp_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          act_o   = ACT_LOAD;
          state_d = S_START;
        end
      end
      S_START: begin
        state_d = S_DONE;
        if (is_ins) begin
          if (stat_i.full) begin
            act_o = ACT_MISS;
          end else begin
            state_d = S_READ;
          end
        end else if (stat_i.func == FUNC_FIND || stat_i.func == FUNC_REMOVE) begin
          state_d = S_READ;
        end else if (stat_i.func == FUNC_CLEAR) begin
          act_o = ACT_CLEAR;
        end else begin
          act_o = ACT_MISS;
        end
      end
      S_READ: begin
        if (stat_i.cnt_done) begin
          act_o   = ACT_MISS;
          state_d = S_DONE;
        end else begin
          act_o   = ACT_READ_IDX;
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        state_d = S_DONE;
        if (is_ins) begin
          priority if (!stat_i.is_used) begin
            act_o = ACT_PLACE;
          end else if (stat_i.key_hit) begin
            act_o = ACT_HIT;
          end else if (stat_i.d_gt) begin
            act_o   = ACT_SWAP;
            state_d = S_READ;
          end else begin
            act_o   = ACT_STEP;
            state_d = S_READ;
          end
        end else if (stat_i.func == FUNC_FIND) begin
          priority if (!stat_i.is_used || stat_i.d_gt) begin
            act_o = ACT_MISS;
          end else if (stat_i.key_hit) begin
            act_o = ACT_HIT;
          end else begin
            act_o   = ACT_STEP;
            state_d = S_READ;
          end
        end else begin
          priority if (!stat_i.is_used) begin
            act_o = ACT_MISS;
          end else if (stat_i.key_hit) begin
            act_o   = ACT_RM_HIT;
            state_d = S_SREAD;
          end else begin
            act_o   = ACT_STEP;
            state_d = S_READ;
          end
        end
      end
      S_SREAD: begin
        if (stat_i.cnt_done) begin
          act_o   = ACT_RM_DONE;
          state_d = S_DONE;
        end else begin
          act_o   = ACT_READ_NEXT;
          state_d = S_SEVAL;
        end
      end
      S_SEVAL: begin
        if (!stat_i.nx_used || stat_i.dist_zero) begin
          act_o   = ACT_RM_DONE;
          state_d = S_DONE;
        end else begin
          act_o   = ACT_SHIFT;
          state_d = S_SREAD;
        end
      end
      S_DONE: begin
        if (!out_valid_q || rsp_ready_i) begin
          act_o       = ACT_EMIT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = out_valid_q;

endmodule

`default_nettype wire

FILE: sv/robin_hood_hash_map.sv
// Top level of the Robin Hood hash map: joins the controller and datapath
// to the request, response and configuration ports. Depends on rhh_pkg,
// rhh_req_if, rhh_rsp_if, rhh_ctrl and rhh_dp.
//
//   Channel   Dir  Handshake            Payload
//   req_i     in   valid / ready        func, key, value, home_slot
//   rsp_o     out  valid / ready        status, slot_index, value_out, entry_count
//   cfg       in   cfg_we_i (no stall)  cfg_data_i = load_limit
//
// An operation loads the request, probes one slot at a time and then emits the
// response; a remove that hits then moves entries back one at a time until it
// finds the end of the run. Clear and refused inserts probe no slot.
// Each probe reads, then evaluates: the slot memory has one read port with
// a registered read, and the next slot is chosen from the data just read.
// Reset clears the used bits, entry count and state machine at once, with no
// clearing pass; the key and value memory is never reset.
// A stalled response waits in the output register; the next request is taken
// while it waits, and its result waits in turn until the register is free.
`default_nettype none

module robin_hood_hash_map (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [rhh_pkg::CNT_W-1:0] cfg_data_i,
  rhh_req_if.sink                   req_i,
  rhh_rsp_if.source                 rsp_o
);
  import rhh_pkg::*;

  // Command and status between the state machine and the datapath.
  act_e     act;
  dp_stat_t stat;

  // The controller accepts a request only when idle and sequences the probe
  // walk, Robin Hood displacement and backward shift one slot at a time.
  rhh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .stat_i      (stat),
    .act_o       (act)
  );

  // The datapath owns the slot memory, the used bits, the load limit and the
  // response register that holds the result while the consumer stalls.
  rhh_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .req_func_i   (req_i.func),
    .req_key_i    (req_i.key),
    .req_value_i  (req_i.value),
    .req_home_i   (req_i.home_slot),
    .act_i        (act),
    .stat_o       (stat),
    .out_status_o (rsp_o.status),
    .out_slot_o   (rsp_o.slot_index),
    .out_value_o  (rsp_o.value_out),
    .out_count_o  (rsp_o.entry_count)
  );

endmodule

`default_nettype wire

FILE: sv/rhh_checker.sv
// Port-level checker of the Robin Hood hash map and its bind statement.
// Depends on rhh_pkg and robin_hood_hash_map_defines.svh.
`default_nettype none
`include "robin_hood_hash_map_defines.svh"

module rhh_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           req_valid_i,
  input logic                           req_ready_i,
  input logic                           rsp_valid_i,
  input logic                           rsp_ready_i,
  input logic [rhh_pkg::STATUS_W-1:0]   rsp_status_i,
  input logic [rhh_pkg::SLOT_W-1:0]     rsp_slot_i,
  input logic [rhh_pkg::VALUE_BITS-1:0] rsp_value_i,
  input logic [rhh_pkg::CNT_W-1:0]      rsp_count_i
);
  import rhh_pkg::*;

  // One transaction at a time: ready drops right after a request is taken.
  `RHH_ASSERT(a_one_at_a_time, req_valid_i && req_ready_i |=> !req_ready_i, "ready stayed high after a request transaction")

  // A stalled response stays valid and holds its status and entry count.
  `RHH_ASSERT(a_rsp_hold, rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_status_i) && $stable(rsp_count_i), "stalled response changed")

  // A clear empties the table.
  `RHH_ASSERT(a_clear_empty, rsp_valid_i && rsp_status_i == ST_CLEARED |-> rsp_count_i == '0, "clear left entries")

  // A refused or missed request reports no slot and no value.
  `RHH_ASSERT(a_miss_zero, rsp_valid_i && (rsp_status_i == ST_FULL || rsp_status_i == ST_NOTFOUND) |-> rsp_slot_i == '0 && rsp_value_i == '0, "miss carried data")

  // The entry count never exceeds the slot count, reset included.
  `RHH_ASSERT_ALWAYS(a_count_range, !rsp_valid_i || rsp_count_i <= CNT_W'(SLOTS), "entry count out of range")

endmodule

bind robin_hood_hash_map rhh_checker u_rhh_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_status_i (rsp_o.status),
  .rsp_slot_i   (rsp_o.slot_index),
  .rsp_value_i  (rsp_o.value_out),
  .rsp_count_i  (rsp_o.entry_count)
);

`default_nettype wire

FILE: test/tb_top.sv
// Self-checking testbench of the Robin Hood hash map: random and directed
// table operations checked against a behavioral table model.
// Depends on rhh_pkg, rhh_req_if, rhh_rsp_if and robin_hood_hash_map.
`timescale 1ns / 100ps

module tb_top;
  import rhh_pkg::*;

  typedef struct packed {
    logic [FUNC_W-1:0]     func;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
    logic [SLOT_W-1:0]     home;
  } request_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [SLOT_W-1:0]     slot;
    logic [VALUE_BITS-1:0] value;
    logic [CNT_W-1:0]      count;
  } answer_t;

  localparam int CYCLE_LIMIT = 5000000;

  logic clk_i;
  logic rst_ni;
  logic cfg_we;
  logic [CNT_W-1:0] cfg_data;

  rhh_req_if req_ch ();
  rhh_rsp_if rsp_ch ();

  robin_hood_hash_map DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data),
    .req_i      (req_ch.sink),
    .rsp_o      (rsp_ch.source)
  );

  // Shadow copy of the table, kept in step with every accepted request.
  logic             tbl_used [SLOTS];
  logic [DIST_W-1:0] tbl_dist [SLOTS];
  logic [KEY_BITS-1:0] tbl_key [SLOTS];
  logic [VALUE_BITS-1:0] tbl_val [SLOTS];
  int unsigned      tbl_count;
  int unsigned      tbl_limit;

  request_t    pending_reqs [$];
  answer_t     expected_answers [$];
  int unsigned fail_count;
  int unsigned cycle_count;
  bit          stall_free;
  // Set at the rising edge that accepted the request on the bus.
  bit          req_taken;

  // Keys that were inserted recently, so that hits are frequent.
  logic [KEY_BITS-1:0] known_keys [$];
  logic [SLOT_W-1:0]   known_homes [$];

  function automatic logic [DIST_W-1:0] clip_dist(int unsigned d);
    return (d > DIST_MAX) ? DIST_MAX : DIST_W'(d);
  endfunction

  // Applies one request to the shadow table and returns the answer.
  function automatic answer_t apply_request(request_t rq);
    answer_t a;
    int unsigned idx, d, od, n, m, last, nx;
    logic [KEY_BITS-1:0] ck, tk;
    logic [VALUE_BITS-1:0] cv, tv;
    bit placed, done;
    a = '0;
    a.status = ST_NOTFOUND;
    idx = rq.home;
    if (rq.func == FUNC_INSERT || rq.func == FUNC_REPLACE) begin
      a.status = ST_FULL;
      if (tbl_count < tbl_limit && tbl_count < SLOTS) begin
        ck = rq.key;
        cv = rq.value;
        d = 0;
        placed = 0;
        done = 0;
        for (n = 0; n < SLOTS && !done; n++) begin
          if (!tbl_used[idx]) begin
            tbl_used[idx] = 1'b1;
            tbl_dist[idx] = clip_dist(d);
            tbl_key[idx] = ck;
            tbl_val[idx] = cv;
            tbl_count++;
            if (!placed) begin
              a.slot = SLOT_W'(idx);
              placed = 1;
            end
            a.status = ST_INSERTED;
            a.value = tbl_val[a.slot];
            done = 1;
          end else if (tbl_key[idx] == ck) begin
            a.slot = SLOT_W'(idx);
            if (rq.func == FUNC_REPLACE) begin
              tbl_val[idx] = rq.value;
              a.status = ST_REPLACED;
            end else begin
              a.status = ST_PRESENT;
            end
            a.value = tbl_val[idx];
            done = 1;
          end else begin
            if (d > tbl_dist[idx]) begin
              od = tbl_dist[idx];
              if (!placed) begin
                a.slot = SLOT_W'(idx);
                placed = 1;
              end
              tbl_dist[idx] = clip_dist(d);
              d = od;
              tk = tbl_key[idx]; tbl_key[idx] = ck; ck = tk;
              tv = tbl_val[idx]; tbl_val[idx] = cv; cv = tv;
            end
            d++;
            idx = (idx + 1) % SLOTS;
          end
        end
        if (a.status == ST_FULL) begin
          a.slot = '0;
          a.value = '0;
        end
      end
    end else if (rq.func == FUNC_FIND) begin
      d = 0;
      done = 0;
      for (n = 0; n < SLOTS && !done; n++) begin
        if (!tbl_used[idx] || d > tbl_dist[idx]) begin
          done = 1;
        end else if (tbl_key[idx] == rq.key) begin
          a.status = ST_FOUND;
          a.slot = SLOT_W'(idx);
          a.value = tbl_val[idx];
          done = 1;
        end else begin
          d++;
          idx = (idx + 1) % SLOTS;
        end
      end
    end else if (rq.func == FUNC_REMOVE) begin
      done = 0;
      for (n = 0; n < SLOTS && !done; n++) begin
        if (!tbl_used[idx]) begin
          done = 1;
        end else if (tbl_key[idx] == rq.key) begin
          a.status = ST_REMOVED;
          a.slot = SLOT_W'(idx);
          a.value = tbl_val[idx];
          last = idx;
          // Backward shift: pull displaced followers one slot closer to home.
          for (m = 0; m < SLOTS; m++) begin
            nx = (last + 1) % SLOTS;
            if (!tbl_used[nx] || tbl_dist[nx] == 0) break;
            tbl_dist[last] = tbl_dist[nx] - 1'b1;
            tbl_key[last] = tbl_key[nx];
            tbl_val[last] = tbl_val[nx];
            last = nx;
          end
          tbl_used[last] = 1'b0;
          tbl_dist[last] = '0;
          if (tbl_count > 0) tbl_count--;
          done = 1;
        end else begin
          idx = (idx + 1) % SLOTS;
        end
      end
    end else if (rq.func == FUNC_CLEAR) begin
      for (n = 0; n < SLOTS; n++) begin
        tbl_used[n] = 1'b0;
        tbl_dist[n] = '0;
      end
      tbl_count = 0;
      a.status = ST_CLEARED;
    end
    a.count = CNT_W'(tbl_count);
    return a;
  endfunction

  function automatic request_t make_req(logic [FUNC_W-1:0] f, logic [KEY_BITS-1:0] k,
                                        logic [VALUE_BITS-1:0] v, logic [SLOT_W-1:0] h);
    request_t r;
    r.func = f;
    r.key = k;
    r.value = v;
    r.home = h;
    return r;
  endfunction

  // Random request: mostly inserts and lookups of recent keys, some noise.
  function automatic request_t random_req(int unsigned fill_bias);
    request_t r;
    int unsigned pick, sel;
    r.value = $urandom;
    pick = $urandom_range(99);
    if (known_keys.size() > 0 && pick >= fill_bias && pick < 92) begin
      sel = $urandom_range(known_keys.size() - 1);
      r.key = known_keys[sel];
      r.home = known_homes[sel];
      case ($urandom_range(3))
        0: r.func = FUNC_INSERT;
        1: r.func = FUNC_REPLACE;
        2: r.func = FUNC_FIND;
        default: r.func = FUNC_REMOVE;
      endcase
    end else begin
      r.key = ($urandom_range(3) == 0) ? KEY_BITS'($urandom_range(15)) : $urandom;
      // A narrow home range builds long clusters and displacement chains.
      r.home = ($urandom_range(1) == 0) ? SLOT_W'($urandom_range(7) + 248)
                                        : SLOT_W'($urandom);
      if (pick < fill_bias) begin
        r.func = ($urandom_range(3) == 0) ? FUNC_REPLACE : FUNC_INSERT;
        known_keys.push_back(r.key);
        known_homes.push_back(r.home);
        if (known_keys.size() > 64) begin
          void'(known_keys.pop_front());
          void'(known_homes.pop_front());
        end
      end else if (pick >= 98) begin
        r.func = FUNC_W'($urandom_range(7, 5));
      end else begin
        r.func = FUNC_W'($urandom_range(3));
      end
    end
    if ($urandom_range(199) == 0) r.func = FUNC_CLEAR;
    return r;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Driver: presents the oldest pending request, idling at random. A request
  // on the bus is held until the rising edge that takes it.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_taken) begin
      if (pending_reqs.size() > 0 && (stall_free || $urandom_range(99) >= 15)) begin
        req_ch.valid <= 1'b1;
        {req_ch.func, req_ch.key, req_ch.value, req_ch.home_slot} <= pending_reqs[0];
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
    rsp_ch.ready <= stall_free || ($urandom_range(99) >= 15);
  end

  // Monitor: predicts on every accepted request, checks every accepted response.
  always @(posedge clk_i) begin
    answer_t got, want;
    if (rst_ni) begin
      cycle_count <= cycle_count + 1;
      req_taken <= req_ch.valid && req_ch.ready;
      if (req_ch.valid && req_ch.ready) begin
        expected_answers.push_back(apply_request(pending_reqs.pop_front()));
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        got = {rsp_ch.status, rsp_ch.slot_index, rsp_ch.value_out, rsp_ch.entry_count};
        if (expected_answers.size() == 0) begin
          $error("response with no request outstanding");
          fail_count++;
        end else begin
          want = expected_answers.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fail_count++;
          end
          if (got.slot !== want.slot) begin
            $error("slot_index: expected %0d, got %0d", want.slot, got.slot);
            fail_count++;
          end
          if (got.value !== want.value) begin
            $error("value_out: expected %h, got %h", want.value, got.value);
            fail_count++;
          end
          if (got.count !== want.count) begin
            $error("entry_count: expected %0d, got %0d", want.count, got.count);
            fail_count++;
          end
        end
      end
    end else begin
      req_taken <= 1'b0;
    end
  end

  // Timeout guard.
  always @(posedge clk_i) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Waits until every queued request has been answered.
  task automatic drain();
    while (pending_reqs.size() > 0 || expected_answers.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // Load limit is only changed with the table idle.
  task automatic set_limit(int unsigned lim);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_data <= CNT_W'(lim);
    tbl_limit = lim;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(int unsigned cnt, int unsigned fill_bias);
    for (int unsigned i = 0; i < cnt; i++) begin
      pending_reqs.push_back(random_req(fill_bias));
      while (pending_reqs.size() > 4) @(posedge clk_i);
    end
  endtask

  initial begin
    fail_count = 0;
    cycle_count = 0;
    stall_free = 0;
    tbl_count = 0;
    tbl_limit = LOAD_RESET;
    for (int i = 0; i < SLOTS; i++) begin
      tbl_used[i] = 1'b0;
      tbl_dist[i] = '0;
      tbl_key[i] = '0;
      tbl_val[i] = '0;
    end
    cfg_we = 1'b0;
    cfg_data = '0;
    req_ch.valid = 1'b0;
    req_ch.func = '0;
    req_ch.key = '0;
    req_ch.value = '0;
    req_ch.home_slot = '0;
    rsp_ch.ready = 1'b0;
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part at the reset limit: extremes, collisions, wraparound,
    // zeroed insert, present key, lookups that miss, unused selectors.
    pending_reqs.push_back(make_req(FUNC_FIND, '0, '0, '0));
    pending_reqs.push_back(make_req(FUNC_INSERT, '1, '1, 8'd255));
    pending_reqs.push_back(make_req(FUNC_INSERT, '0, '0, 8'd255));
    pending_reqs.push_back(make_req(FUNC_INSERT, 32'd5, 32'd77, 8'd0));
    pending_reqs.push_back(make_req(FUNC_INSERT, '1, 32'd9, 8'd255));
    pending_reqs.push_back(make_req(FUNC_REPLACE, '0, 32'hA5A5A5A5, 8'd255));
    pending_reqs.push_back(make_req(FUNC_REPLACE, 32'd6, 32'd66, 8'd1));
    pending_reqs.push_back(make_req(FUNC_FIND, 32'd5, '0, 8'd0));
    pending_reqs.push_back(make_req(FUNC_FIND, 32'd6, '0, 8'd1));
    pending_reqs.push_back(make_req(FUNC_FIND, 32'd123, '0, 8'd255));
    pending_reqs.push_back(make_req(FUNC_REMOVE, '1, '0, 8'd255));
    pending_reqs.push_back(make_req(FUNC_FIND, '0, '0, 8'd255));
    pending_reqs.push_back(make_req(FUNC_REMOVE, 32'd999, '0, 8'd3));
    pending_reqs.push_back(make_req(3'd5, 32'd5, 32'd1, 8'd0));
    pending_reqs.push_back(make_req(3'd6, '1, '1, '1));
    pending_reqs.push_back(make_req(3'd7, '0, '0, '0));
    pending_reqs.push_back(make_req(FUNC_CLEAR, '0, '0, '0));
    pending_reqs.push_back(make_req(FUNC_FIND, 32'd5, '0, 8'd0));
    drain();

    // Limit of one: the second insert is refused even for a present key.
    set_limit(1);
    pending_reqs.push_back(make_req(FUNC_INSERT, 32'd42, 32'd1, 8'd10));
    pending_reqs.push_back(make_req(FUNC_INSERT, 32'd42, 32'd2, 8'd10));
    pending_reqs.push_back(make_req(FUNC_REPLACE, 32'd43, 32'd3, 8'd11));
    pending_reqs.push_back(make_req(FUNC_CLEAR, '0, '0, '0));
    drain();

    // Full capacity: every slot can fill, and long probe walks saturate.
    set_limit(SLOTS);
    run_random(350, 80);
    // The sender holds off until the table has answered everything.
    drain();

    // Stretch with no idling on either side.
    stall_free = 1;
    run_random(150, 55);
    stall_free = 0;
    drain();

    set_limit(511);
    run_random(150, 60);
    drain();

    set_limit(40);
    run_random(200, 50);
    drain();

    set_limit(LOAD_RESET);
    pending_reqs.push_back(make_req(FUNC_CLEAR, '0, '0, '0));
    run_random(300, 60);
    drain();

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
